>>> sv/rational_arith_unit_top_macros.svh
// Assertion macros shared by the rational arithmetic unit.
// Included by the modules that carry concurrent checks.
`ifndef RATIONAL_ARITH_UNIT_TOP_MACROS_SVH
`define RATIONAL_ARITH_UNIT_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define RAU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that holds during reset as well.
`define RAU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/rau_pkg.sv
// Package for the rational arithmetic unit: widths, operation codes, states.
// No dependencies.
`default_nettype none
package rau_pkg;
    localparam int OpW  = 16;
    localparam int NumW = 2 * OpW;
    localparam int DenW = 2 * OpW - 2;
    localparam int MagW = 2 * OpW + 1;
    localparam int CntW = $clog2(MagW + 1);

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_PREP,
        ST_GCD,
        ST_DIVN_INIT,
        ST_DIVN,
        ST_DIVD_INIT,
        ST_DIVD,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;
endpackage
`default_nettype wire

>>> sv/rau_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on rau_pkg and the assertion macro header.
`default_nettype none
`include "rational_arith_unit_top_macros.svh"
module rau_divider
    import rau_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [MagW-1:0] dividend,
    input  wire logic [MagW-1:0] divisor,
    output div_ctl_t             ctl,
    output logic     [MagW-1:0] quotient,
    output logic     [MagW-1:0] remainder
);
    logic [MagW-1:0] quo_reg, quo_next;
    logic [MagW-1:0] rem_reg, rem_next;
    logic [MagW-1:0] dvs_reg, dvs_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [MagW:0]   trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[MagW-1]} - {1'b0, dvs_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CntW'(MagW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[MagW])
            begin
                rem_next = trial[MagW-1:0];
                quo_next = {quo_reg[MagW-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[MagW-2:0], quo_reg[MagW-1]};
                quo_next = {quo_reg[MagW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    `RAU_ASSERT(a_done_after_busy, done_reg |-> $past(busy_reg), "done without busy")
    `RAU_ASSERT(a_busy_count, busy_reg |-> (cnt_reg != '0), "busy with zero count")
    `RAU_ASSERT(a_not_both, !(busy_reg && done_reg), "busy and done together")
endmodule
`default_nettype wire

>>> sv/rational_arith_unit_top.sv
// Top level of the rational arithmetic unit: cross products, sign fix, gcd reduction.
// Depends on rau_pkg, rau_divider and the assertion macro header.
//
//   channel  direction  handshake       payload
//   in       input      in_valid/stall  action a_num a_den b_num b_den
//   out      output     out_valid/stall res_num res_den den_zero
//
// One request at a time. Two 16x16 products in ST_MUL1 and one in ST_MUL2 form
// the numerator and denominator. The gcd runs as Euclid steps on a shared
// bit-serial divider (per remainder: launch, 33 quotient bits, done), then the
// same divider reduces numerator and denominator. Reset clears the control state
// only. A finished result waits in the output registers while out_stall is high;
// the next request is still taken and, once computed, waits in ST_DONE until the
// output registers are free.
`default_nettype none
`include "rational_arith_unit_top_macros.svh"
module rational_arith_unit_top
    import rau_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [1:0]             action,
    input  wire logic signed [OpW-1:0]  a_num,
    input  wire logic signed [OpW-1:0]  a_den,
    input  wire logic signed [OpW-1:0]  b_num,
    input  wire logic signed [OpW-1:0]  b_den,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic signed [NumW-1:0]      res_num,
    output logic        [DenW-1:0]      res_den,
    output logic                        den_zero
);
    state_t state_reg, state_next;

    logic [1:0]               act_reg;
    logic signed [OpW-1:0]    an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [2*OpW:0]    p1_reg, p1_next, p2_reg, p2_next;
    logic signed [2*OpW+1:0]  n_reg, n_next;
    logic signed [2*OpW+1:0]  d_reg, d_next;
    logic [MagW-1:0]          nm_reg, nm_next, dm_reg, dm_next;
    logic [MagW-1:0]          gp_reg, gp_next, gq_reg, gq_next;
    logic                     neg_reg, neg_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [NumW-1:0]   res_num_reg, res_num_next;
    logic [DenW-1:0]          res_den_reg, res_den_next;
    logic                     dz_reg, dz_next;

    logic                     div_start;
    logic [MagW-1:0]          div_a, div_b, div_q, div_r;
    div_ctl_t                 div_ctl;
    logic signed [2*OpW+1:0]  n_fix, d_fix;
    logic [MagW-1:0]          nm_sat, dm_sat;
    logic                     out_busy;

    // A divider pass was launched last cycle.
    logic div_start_pend;
    logic pend_reg;

    localparam logic [MagW-1:0] NumMax = MagW'((64'd1 << (NumW - 1)) - 64'd1);
    localparam logic [MagW-1:0] DenMax = MagW'((64'd1 << DenW) - 64'd1);

    rau_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .ctl       (div_ctl),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // The output registers still hold a result that is not taken this cycle.
    assign out_busy = out_valid_reg && out_stall;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_MUL1;
            ST_MUL1:      state_next = ST_MUL2;
            ST_MUL2:      state_next = ST_PREP;
            ST_PREP:      state_next = ST_GCD;
            ST_GCD:
                if (gq_reg == '0) state_next = ST_DIVN_INIT;
            ST_DIVN_INIT: state_next = ST_DIVN;
            ST_DIVN:      if (div_ctl.done) state_next = ST_DIVD_INIT;
            ST_DIVD_INIT: state_next = ST_DIVD;
            ST_DIVD:      if (div_ctl.done) state_next = ST_DONE;
            ST_DONE:      if (!out_busy) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Datapath and output logic.
    always_comb
    begin
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        nm_next        = nm_reg;
        dm_next        = dm_reg;
        gp_next        = gp_reg;
        gq_next        = gq_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg;
        res_num_next   = res_num_reg;
        res_den_next   = res_den_reg;
        dz_next        = dz_reg;
        div_start      = 1'b0;
        div_a          = gp_reg;
        div_b          = gq_reg;
        n_fix          = (d_reg < 0) ? -n_reg : n_reg;
        d_fix          = (d_reg < 0) ? -d_reg : d_reg;
        nm_sat         = (div_q > NumMax) ? NumMax : div_q;
        dm_sat         = (div_q > DenMax) ? DenMax : div_q;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_MUL1:
            begin
                // The two numerator-side products, formed in ST_MUL1.
                unique case (action_t'(act_reg))
                    ACT_MUL: p1_next = (2*OpW+1)'(an_reg * bn_reg);
                    default: p1_next = (2*OpW+1)'(an_reg * bd_reg);
                endcase
                p2_next = (2*OpW+1)'(bn_reg * ad_reg);
            end
            ST_MUL2:
            begin
                unique case (action_t'(act_reg))
                    ACT_ADD: n_next = (2*OpW+2)'(p1_reg) + (2*OpW+2)'(p2_reg);
                    ACT_SUB: n_next = (2*OpW+2)'(p1_reg) - (2*OpW+2)'(p2_reg);
                    default: n_next = (2*OpW+2)'(p1_reg);
                endcase
                if (action_t'(act_reg) == ACT_DIV)
                    d_next = (2*OpW+2)'(ad_reg * bn_reg);
                else
                    d_next = (2*OpW+2)'(ad_reg * bd_reg);
            end
            ST_PREP:
            begin
                // Move the denominator's sign to the numerator.
                neg_next = n_fix < 0;
                nm_next  = MagW'((n_fix < 0) ? -n_fix : n_fix);
                dm_next  = MagW'(d_fix);
                gp_next  = MagW'((n_fix < 0) ? -n_fix : n_fix);
                gq_next  = MagW'(d_fix);
                if (n_fix == 0)
                begin
                    nm_next = '0;
                    dm_next = MagW'(1);
                    gp_next = MagW'(1);
                    gq_next = '0;
                    neg_next = 1'b0;
                end
            end
            ST_GCD:
            begin
                // One Euclid step per divider pass.
                if (gq_reg != '0)
                begin
                    if (!div_ctl.busy && !div_ctl.done && !div_start_pend)
                        div_start = 1'b1;
                    if (div_ctl.done)
                    begin
                        gp_next = gq_reg;
                        gq_next = div_r;
                    end
                end
            end
            ST_DIVN_INIT:
            begin
                div_a     = nm_reg;
                div_b     = gp_reg;
                div_start = 1'b1;
            end
            ST_DIVN:
                if (div_ctl.done) nm_next = nm_sat;
            ST_DIVD_INIT:
            begin
                div_a     = dm_reg;
                div_b     = gp_reg;
                div_start = 1'b1;
            end
            ST_DIVD:
                if (div_ctl.done) dm_next = dm_sat;
            ST_DONE:
            begin
                // Load the output registers once the previous result has left.
                if (!out_busy)
                begin
                    res_num_next   = neg_reg ? -NumW'(nm_reg) : NumW'(nm_reg);
                    res_den_next   = DenW'(dm_reg);
                    dz_next        = (dm_reg == '0);
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign div_start_pend = pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= div_start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            act_reg <= action;
            an_reg  <= a_num;
            ad_reg  <= a_den;
            bn_reg  <= b_num;
            bd_reg  <= b_den;
        end
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        n_reg       <= n_next;
        d_reg       <= d_next;
        nm_reg      <= nm_next;
        dm_reg      <= dm_next;
        gp_reg      <= gp_next;
        gq_reg      <= gq_next;
        neg_reg     <= neg_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        dz_reg      <= dz_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;
    assign den_zero  = dz_reg;

    `RAU_ASSERT(a_stall_busy, (state_reg != ST_IDLE) |-> in_stall, "request taken while busy")
    `RAU_ASSERT(a_done_valid, (state_reg == ST_DONE) |=> out_valid, "result not presented")
    `RAU_ASSERT(a_dz_den, out_valid |-> (den_zero == (res_den == '0)), "den_zero mismatch")
endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the rational arithmetic unit: directed and random requests.
// Depends on rau_pkg and rational_arith_unit_top; predicts each fraction result internally.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import rau_pkg::*;

    // One reduced fraction as the block reports it.
    typedef struct packed {
        logic signed [NumW-1:0] num;
        logic [DenW-1:0]        den;
        logic                   dz;
    } fraction_t;

    localparam int CycleLimit = 20000000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [1:0]             action = ACT_ADD;
    logic signed [OpW-1:0]  a_num = '0;
    logic signed [OpW-1:0]  a_den = '0;
    logic signed [OpW-1:0]  b_num = '0;
    logic signed [OpW-1:0]  b_den = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic signed [NumW-1:0] res_num;
    logic [DenW-1:0]        res_den;
    logic                   den_zero;

    fraction_t pending_fractions[$];
    int        error_count = 0;
    int        cycle_count = 0;
    // The receiver idles at random only when this is set.
    bit        sink_jitter = 1'b1;
    // A long hold-off on the output, counted by the stall process.
    int        hold_cycles = 0;
    // The sender idles at random only when this is set.
    bit        source_jitter = 1'b1;

    rational_arith_unit_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .action   (action),
        .a_num    (a_num),
        .a_den    (a_den),
        .b_num    (b_num),
        .b_den    (b_den),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .res_num  (res_num),
        .res_den  (res_den),
        .den_zero (den_zero)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Cross products, sign fix, Euclid reduction and saturation, done in wide integers.
    function automatic fraction_t reduce_fraction(logic [1:0] op, logic signed [OpW-1:0] an,
                                                  logic signed [OpW-1:0] ad,
                                                  logic signed [OpW-1:0] bn,
                                                  logic signed [OpW-1:0] bd);
        longint    n;
        longint    d;
        longint    p;
        longint    q;
        longint    r;
        longint    nm;
        longint    dm;
        bit        neg;
        fraction_t f;
        case (op)
            ACT_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
            ACT_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
            ACT_MUL: begin n = an * bn; d = ad * bd; end
            default: begin n = an * bd; d = ad * bn; end
        endcase
        if (d < 0)
        begin
            n = -n;
            d = -d;
        end
        if (n == 0)
        begin
            nm = 0;
            dm = 1;
            neg = 1'b0;
        end
        else
        begin
            neg = n < 0;
            nm = neg ? -n : n;
            dm = d;
            p = nm;
            q = dm;
            while (q != 0)
            begin
                r = p % q;
                p = q;
                q = r;
            end
            nm = nm / p;
            dm = dm / p;
        end
        // Only the most negative operand can push a result past these bounds.
        if (nm > (64'sd1 <<< (NumW - 1)) - 1)
            nm = (64'sd1 <<< (NumW - 1)) - 1;
        if (dm > (64'sd1 <<< DenW) - 1)
            dm = (64'sd1 <<< DenW) - 1;
        f.num = NumW'(neg ? -nm : nm);
        f.den = DenW'(dm);
        f.dz = dm == 0;
        return f;
    endfunction

    // Offers one request and holds it until the block takes it. Valid stays high
    // afterwards; the next request or release_input takes it down.
    task automatic send_request(logic [1:0] op, logic signed [OpW-1:0] an,
                                logic signed [OpW-1:0] ad, logic signed [OpW-1:0] bn,
                                logic signed [OpW-1:0] bd);
        while (source_jitter && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= op;
        a_num <= an;
        a_den <= ad;
        b_num <= bn;
        b_den <= bd;
        pending_fractions.push_back(reduce_fraction(op, an, ad, bn, bd));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stops offering after the last request was taken.
    task automatic release_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        release_input();
        while (pending_fractions.size() != 0)
            @(posedge clk);
    endtask

    // Random operand: half the time across the full range including the most
    // negative code, otherwise mostly small, sometimes zero.
    function automatic logic signed [OpW-1:0] pick_operand();
        int sel;
        sel = $urandom_range(99);
        if (sel < 8)
            return '0;
        if (sel < 50)
            return $signed(16'($urandom_range(40))) - 16'sd20;
        return 16'($urandom);
    endfunction

    task automatic test_directed();
        logic signed [OpW-1:0] mx;
        logic signed [OpW-1:0] mn;
        mx = 16'sd32767;
        mn = -16'sd32768;
        send_request(ACT_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3);
        send_request(ACT_SUB, 16'sd1, 16'sd2, 16'sd1, 16'sd2);
        send_request(ACT_MUL, -16'sd4, 16'sd6, 16'sd3, -16'sd8);
        send_request(ACT_DIV, 16'sd5, 16'sd7, -16'sd10, 16'sd14);
        // Zero over zero reduces to 0/1.
        send_request(ACT_MUL, 16'sd0, 16'sd0, 16'sd5, 16'sd0);
        // Division by zero in both signs.
        send_request(ACT_DIV, 16'sd3, 16'sd4, 16'sd0, 16'sd9);
        send_request(ACT_DIV, -16'sd3, 16'sd4, 16'sd0, 16'sd9);
        send_request(ACT_ADD, 16'sd1, 16'sd0, 16'sd1, 16'sd5);
        // Extremes of the stated range.
        send_request(ACT_ADD, mx, mx, mx, mx);
        send_request(ACT_SUB, -mx, mx, mx, -mx);
        send_request(ACT_MUL, mx, 16'sd1, mx, 16'sd1);
        send_request(ACT_DIV, 16'sd1, mx, mx, 16'sd1);
        send_request(ACT_ADD, mx, 16'sd1, mx, 16'sd1);
        send_request(ACT_MUL, -mx, 16'sd1, mx, 16'sd1);
        // The most negative code, where saturation can kick in.
        send_request(ACT_MUL, mn, 16'sd1, mn, 16'sd1);
        send_request(ACT_ADD, mn, 16'sd1, mn, 16'sd1);
        send_request(ACT_MUL, 16'sd1, mn, 16'sd1, mn);
        send_request(ACT_DIV, mn, 16'sd1, 16'sd1, mn);
        send_request(ACT_SUB, mn, -16'sd1, mx, 16'sd1);
        send_request(ACT_DIV, 16'sd1, mn, mn, 16'sd1);
        wait_drained();
    endtask

    task automatic test_random(int count);
        repeat (count)
            send_request(2'($urandom_range(3)), pick_operand(), pick_operand(),
                         pick_operand(), pick_operand());
    endtask

    // Receiver holds off while the sender keeps offering, so the block backs up.
    task automatic test_backpressure();
        hold_cycles = 8000;
        test_random(6);
        release_input();
        wait (hold_cycles == 0);
    endtask

    // Sender pauses until every result has arrived, then resumes.
    task automatic test_sender_pause();
        test_random(10);
        wait_drained();
        test_random(10);
    endtask

    // Stretch with no idling on either side.
    task automatic test_no_idle();
        sink_jitter = 1'b0;
        source_jitter = 1'b0;
        test_random(150);
        wait_drained();
        sink_jitter = 1'b1;
        source_jitter = 1'b1;
    endtask

    // Output stall: random idling, or a counted hold-off when requested.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_stall <= sink_jitter && ($urandom_range(99) < 18);
    end

    // Result checker: every accepted result is matched to the oldest expectation.
    always @(posedge clk)
    begin
        fraction_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_fractions.size() == 0)
            begin
                $error("unexpected result %0d/%0d", res_num, res_den);
                error_count++;
            end
            else
            begin
                want = pending_fractions.pop_front();
                if (res_num !== want.num)
                begin
                    $error("res_num expected %0d actual %0d", want.num, res_num);
                    error_count++;
                end
                if (res_den !== want.den)
                begin
                    $error("res_den expected %0d actual %0d", want.den, res_den);
                    error_count++;
                end
                if (den_zero !== want.dz)
                begin
                    $error("den_zero expected %0d actual %0d", want.dz, den_zero);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on the cycle count.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_sender_pause();
        test_no_idle();
        test_random(1200);
        wait_drained();
        // No more results may come.
        repeat (3000) @(posedge clk);
        if (error_count == 0 && pending_fractions.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

>>> files.f
+incdir+sv
sv/rau_pkg.sv
sv/rau_divider.sv
sv/rational_arith_unit_top.sv
tb/testbench.sv
